// ----- design/cpvp_pkg.sv -----
// Shared types, constants and register codes of the cascaded position/velocity controller.
package cpvp_pkg;

  localparam int unsigned MAG_W     = 64;
  localparam int unsigned GAIN_W    = 15;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned MUL_STEPS = 15;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;

  localparam logic [7:0]  DRIVE_CENTER  = 8'd127;
  localparam logic [GAIN_W-1:0] DIVISOR_RESET = 15'd1;
  localparam logic [GAIN_W-1:0] LIMIT_RESET   = 15'h7FFF;
  localparam logic [15:0] WINDOW_RESET  = 16'd10;

  typedef enum logic [2:0] {
    REG_CASCADE_MODE     = 3'd0,
    REG_POSITION_GAIN    = 3'd1,
    REG_GAIN_DIVISOR     = 3'd2,
    REG_VELOCITY_P_GAIN  = 3'd3,
    REG_VELOCITY_I_GAIN  = 3'd4,
    REG_VELOCITY_LIMIT   = 3'd5,
    REG_MOTOR_REVERSE    = 3'd6,
    REG_ON_TARGET_WINDOW = 3'd7
  } reg_idx_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } md_op_t;

  typedef struct packed {
    logic                     start;
    md_op_t                   op;
    logic signed [MAG_W-1:0]  a;
    logic [GAIN_W-1:0]        b;
  } md_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [MAG_W-1:0]  result;
  } md_rsp_t;

  typedef struct packed {
    logic              cascade_mode;
    logic [GAIN_W-1:0] position_gain;
    logic [GAIN_W-1:0] gain_divisor;
    logic [GAIN_W-1:0] velocity_p_gain;
    logic [GAIN_W-1:0] velocity_i_gain;
    logic [GAIN_W-1:0] velocity_limit;
    logic              motor_reverse;
    logic [15:0]       on_target_window;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_CMD_MUL,
    S_CMD_DIV,
    S_CMD,
    S_VERR,
    S_I_MUL,
    S_I_DIV,
    S_SUM,
    S_D_MUL,
    S_D_DIV,
    S_FIN
  } state_t;

endpackage

// ----- design/cpvp_if.sv -----
// Valid/ready channel interfaces for control ticks and controller results.
interface cpvp_tick_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] encoder_count;
  logic signed [31:0] position_target;
  logic signed [15:0] velocity_target;

  modport source (output valid, encoder_count, position_target, velocity_target, input ready);
  modport sink   (input valid, encoder_count, position_target, velocity_target, output ready);
endinterface

interface cpvp_result_if;
  logic               valid;
  logic               ready;
  logic [7:0]         drive;
  logic               position_on_target;
  logic signed [31:0] measured_velocity;
  logic signed [15:0] velocity_command;

  modport source (output valid, drive, position_on_target, measured_velocity, velocity_command,
                  input ready);
  modport sink   (input valid, drive, position_on_target, measured_velocity, velocity_command,
                  output ready);
endinterface

// ----- design/cpvp_regs.sv -----
// APB configuration register file of the controller.
module cpvp_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cpvp_pkg::ADDR_W-1:0]   paddr,
  input  logic [cpvp_pkg::DATA_W-1:0]   pwdata,
  output logic [cpvp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output cpvp_pkg::cfg_t                cfg
);

  logic               wr;
  cpvp_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = cpvp_pkg::reg_idx_t'(paddr[cpvp_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cascade_mode     <= 1'b0;
      cfg.position_gain    <= '0;
      cfg.gain_divisor     <= cpvp_pkg::DIVISOR_RESET;
      cfg.velocity_p_gain  <= '0;
      cfg.velocity_i_gain  <= '0;
      cfg.velocity_limit   <= cpvp_pkg::LIMIT_RESET;
      cfg.motor_reverse    <= 1'b0;
      cfg.on_target_window <= cpvp_pkg::WINDOW_RESET;
    end else if (wr) begin
      case (idx)
        cpvp_pkg::REG_CASCADE_MODE:     cfg.cascade_mode     <= pwdata[0];
        cpvp_pkg::REG_POSITION_GAIN:    cfg.position_gain    <= pwdata[cpvp_pkg::GAIN_W-1:0];
        cpvp_pkg::REG_GAIN_DIVISOR:     cfg.gain_divisor     <= pwdata[cpvp_pkg::GAIN_W-1:0];
        cpvp_pkg::REG_VELOCITY_P_GAIN:  cfg.velocity_p_gain  <= pwdata[cpvp_pkg::GAIN_W-1:0];
        cpvp_pkg::REG_VELOCITY_I_GAIN:  cfg.velocity_i_gain  <= pwdata[cpvp_pkg::GAIN_W-1:0];
        cpvp_pkg::REG_VELOCITY_LIMIT:   cfg.velocity_limit   <= pwdata[cpvp_pkg::GAIN_W-1:0];
        cpvp_pkg::REG_MOTOR_REVERSE:    cfg.motor_reverse    <= pwdata[0];
        cpvp_pkg::REG_ON_TARGET_WINDOW: cfg.on_target_window <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      cpvp_pkg::REG_CASCADE_MODE:     prdata = 32'(cfg.cascade_mode);
      cpvp_pkg::REG_POSITION_GAIN:    prdata = 32'(cfg.position_gain);
      cpvp_pkg::REG_GAIN_DIVISOR:     prdata = 32'(cfg.gain_divisor);
      cpvp_pkg::REG_VELOCITY_P_GAIN:  prdata = 32'(cfg.velocity_p_gain);
      cpvp_pkg::REG_VELOCITY_I_GAIN:  prdata = 32'(cfg.velocity_i_gain);
      cpvp_pkg::REG_VELOCITY_LIMIT:   prdata = 32'(cfg.velocity_limit);
      cpvp_pkg::REG_MOTOR_REVERSE:    prdata = 32'(cfg.motor_reverse);
      cpvp_pkg::REG_ON_TARGET_WINDOW: prdata = 32'(cfg.on_target_window);
      default:                        prdata = '0;
    endcase
  end

endmodule

// ----- design/cpvp_muldiv.sv -----
// Shared serial unit: shift-add multiply and restoring divide of a signed word by a gain.
module cpvp_muldiv (
  input  logic              clk,
  input  logic              rst,
  input  cpvp_pkg::md_req_t req,
  output cpvp_pkg::md_rsp_t rsp
);

  logic                              busy;
  logic                              done;
  cpvp_pkg::md_op_t                  op;
  logic                              neg;
  logic [cpvp_pkg::MAG_W-1:0]        mag;
  logic [cpvp_pkg::MAG_W-1:0]        acc;
  logic [cpvp_pkg::GAIN_W-1:0]       bsh;
  logic [cpvp_pkg::GAIN_W-1:0]       rem;
  logic [cpvp_pkg::CNT_W-1:0]        cnt;
  logic                              last;
  logic [cpvp_pkg::GAIN_W+1:0]       trial;
  logic [cpvp_pkg::MAG_W-1:0]        a_mag;
  logic [cpvp_pkg::MAG_W-1:0]        res_mag;

  assign a_mag = req.a[cpvp_pkg::MAG_W-1] ? cpvp_pkg::MAG_W'(-req.a) : req.a;
  assign last  = (op == cpvp_pkg::OP_MUL) ? (cnt == cpvp_pkg::CNT_W'(cpvp_pkg::MUL_STEPS - 1))
                                          : (cnt == cpvp_pkg::CNT_W'(cpvp_pkg::DIV_STEPS - 1));
  // One quotient bit per cycle: shift in the next dividend bit and try the subtraction.
  assign trial = {1'b0, rem, mag[cpvp_pkg::MAG_W-1]} - {2'b00, bsh};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && last) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      neg <= req.a[cpvp_pkg::MAG_W-1];
      mag <= a_mag;
      bsh <= req.b;
      acc <= '0;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      case (op)
        cpvp_pkg::OP_MUL: begin
          if (bsh[0]) begin
            acc <= acc + mag;
          end
          mag <= {mag[cpvp_pkg::MAG_W-2:0], 1'b0};
          bsh <= bsh >> 1;
        end
        cpvp_pkg::OP_DIV: begin
          if (!trial[cpvp_pkg::GAIN_W+1]) begin
            rem <= trial[cpvp_pkg::GAIN_W-1:0];
          end else begin
            rem <= {rem[cpvp_pkg::GAIN_W-2:0], mag[cpvp_pkg::MAG_W-1]};
          end
          mag <= {mag[cpvp_pkg::MAG_W-2:0], ~trial[cpvp_pkg::GAIN_W+1]};
        end
        default: ;
      endcase
    end
  end

  // Magnitudes are exact, so restoring the sign truncates the quotient toward zero.
  assign res_mag    = (op == cpvp_pkg::OP_MUL) ? acc : mag;
  assign rsp.done   = done;
  assign rsp.result = neg ? -$signed(res_mag) : $signed(res_mag);

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy && !done)
    else $error("serial unit started while an operation was in flight");
`endif

endmodule

// ----- design/cascaded_position_velocity_pid.sv -----
// Cascaded position/velocity PI motor controller: sequencer, datapath and result register.
//
// One transfer on the tick channel carries an encoder count, a position target and a
// velocity target; the block answers with exactly one transfer on the result channel
// holding the drive value (127 is stop), the on-target flag, the measured velocity
// and the clamped velocity command. Configuration goes through the APB port, with
// register i at byte address 4*i; writes complete in the access cycle.
// All products and quotients run through one serial multiply/divide unit; a divide
// yields one quotient bit per cycle over 64 bits. In cascade mode an item needs three
// multiplies and three divides; in velocity mode it needs two multiplies and two divides.
// The block takes one item at a time; tick ready rises at the same clock edge that loads
// the result into the output register, so the next tick may be accepted while that
// result still waits. If the receiver stalls and the output register is full, the
// sequencer holds the finished item in its last step and the integral is not updated
// until the result can be stored. Reset (synchronous, active high) clears the previous
// encoder count and the integral to zero, loads the register defaults and drops
// result valid.
module cascaded_position_velocity_pid (
  input  logic                          clk,
  input  logic                          rst,
  cpvp_tick_if.sink                     tick,
  cpvp_result_if.source                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cpvp_pkg::ADDR_W-1:0]   paddr,
  input  logic [cpvp_pkg::DATA_W-1:0]   pwdata,
  output logic [cpvp_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  cpvp_pkg::cfg_t     cfg;
  cpvp_pkg::md_req_t  md_req;
  cpvp_pkg::md_rsp_t  md_rsp;
  cpvp_pkg::state_t   state;
  cpvp_pkg::state_t   state_next;
  logic               launched;
  logic               launched_next;
  logic               fin_go;

  logic signed [31:0] enc_q;
  logic signed [31:0] ptgt_q;
  logic signed [15:0] vtgt_q;
  logic signed [31:0] prev_enc;
  logic signed [31:0] integral;
  logic signed [32:0] pos_err;
  logic signed [31:0] vel;
  logic signed [15:0] cmd;
  logic signed [33:0] vel_err;
  logic               on_tgt;
  logic signed [cpvp_pkg::MAG_W-1:0] work;

  logic               out_valid;
  logic [7:0]         out_drive;
  logic               out_on;
  logic signed [31:0] out_vel;
  logic signed [15:0] out_cmd;

  logic [cpvp_pkg::GAIN_W-1:0]       div_eff;
  logic signed [32:0]                vel_diff;
  logic signed [31:0]                vel_sat;
  logic signed [cpvp_pkg::MAG_W-1:0] raw_cmd;
  logic signed [cpvp_pkg::MAG_W-1:0] lim_w;
  logic signed [15:0]                lim16;
  logic signed [15:0]                cmd_clamped;
  logic signed [32:0]                win33;
  logic signed [34:0]                integ_sum;
  logic signed [31:0]                integ_sat;
  logic                              d_hi;
  logic                              d_lo;
  logic                              d_clamped;
  logic [7:0]                        dc;
  logic [7:0]                        drive_val;

  cpvp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpvp_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // A zero divisor behaves as one.
  assign div_eff = (cfg.gain_divisor == '0) ? cpvp_pkg::DIVISOR_RESET : cfg.gain_divisor;

  assign vel_diff = {enc_q[31], enc_q} - {prev_enc[31], prev_enc};
  always_comb begin
    if (vel_diff[32] != vel_diff[31]) begin
      vel_sat = vel_diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      vel_sat = vel_diff[31:0];
    end
  end

  assign raw_cmd = cfg.cascade_mode ? work
                                    : {{(cpvp_pkg::MAG_W-16){vtgt_q[15]}}, vtgt_q};
  assign lim_w   = {{(cpvp_pkg::MAG_W-cpvp_pkg::GAIN_W){1'b0}}, cfg.velocity_limit};
  assign lim16   = {1'b0, cfg.velocity_limit};
  always_comb begin
    if (raw_cmd > lim_w) begin
      cmd_clamped = lim16;
    end else if (raw_cmd < -lim_w) begin
      cmd_clamped = -lim16;
    end else begin
      cmd_clamped = raw_cmd[15:0];
    end
  end

  assign win33 = {17'b0, cfg.on_target_window};

  assign integ_sum = {{3{integral[31]}}, integral} + {vel_err[33], vel_err};
  always_comb begin
    if (integ_sum[34:31] == 4'b0000 || integ_sum[34:31] == 4'b1111) begin
      integ_sat = integ_sum[31:0];
    end else begin
      integ_sat = integ_sum[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
  end

  assign d_hi      = work > 64'sd127;
  assign d_lo      = work < -64'sd127;
  assign d_clamped = d_hi | d_lo;
  assign dc        = d_hi ? 8'd127 : (d_lo ? 8'h81 : work[7:0]);
  assign drive_val = cfg.motor_reverse ? cpvp_pkg::DRIVE_CENTER - dc
                                       : cpvp_pkg::DRIVE_CENTER + dc;

  always_comb begin
    state_next    = state;
    launched_next = launched;
    fin_go        = 1'b0;
    md_req.start  = 1'b0;
    md_req.op     = cpvp_pkg::OP_MUL;
    md_req.a      = work;
    md_req.b      = div_eff;
    tick.ready    = (state == cpvp_pkg::S_IDLE);
    case (state)
      cpvp_pkg::S_IDLE: begin
        if (tick.valid) begin
          state_next = cpvp_pkg::S_ERR;
        end
      end
      cpvp_pkg::S_ERR: begin
        state_next = cfg.cascade_mode ? cpvp_pkg::S_CMD_MUL : cpvp_pkg::S_CMD;
      end
      cpvp_pkg::S_CMD_MUL: begin
        md_req.start  = !launched;
        md_req.a      = {{(cpvp_pkg::MAG_W-33){pos_err[32]}}, pos_err};
        md_req.b      = cfg.position_gain;
        launched_next = 1'b1;
        if (md_rsp.done) begin
          launched_next = 1'b0;
          state_next    = cpvp_pkg::S_CMD_DIV;
        end
      end
      cpvp_pkg::S_CMD_DIV: begin
        md_req.start  = !launched;
        md_req.op     = cpvp_pkg::OP_DIV;
        launched_next = 1'b1;
        if (md_rsp.done) begin
          launched_next = 1'b0;
          state_next    = cpvp_pkg::S_CMD;
        end
      end
      cpvp_pkg::S_CMD: begin
        state_next = cpvp_pkg::S_VERR;
      end
      cpvp_pkg::S_VERR: begin
        state_next = cpvp_pkg::S_I_MUL;
      end
      cpvp_pkg::S_I_MUL: begin
        md_req.start  = !launched;
        md_req.a      = {{(cpvp_pkg::MAG_W-32){integral[31]}}, integral};
        md_req.b      = cfg.velocity_i_gain;
        launched_next = 1'b1;
        if (md_rsp.done) begin
          launched_next = 1'b0;
          state_next    = cpvp_pkg::S_I_DIV;
        end
      end
      cpvp_pkg::S_I_DIV: begin
        md_req.start  = !launched;
        md_req.op     = cpvp_pkg::OP_DIV;
        launched_next = 1'b1;
        if (md_rsp.done) begin
          launched_next = 1'b0;
          state_next    = cpvp_pkg::S_SUM;
        end
      end
      cpvp_pkg::S_SUM: begin
        state_next = cpvp_pkg::S_D_MUL;
      end
      cpvp_pkg::S_D_MUL: begin
        md_req.start  = !launched;
        md_req.b      = cfg.velocity_p_gain;
        launched_next = 1'b1;
        if (md_rsp.done) begin
          launched_next = 1'b0;
          state_next    = cpvp_pkg::S_D_DIV;
        end
      end
      cpvp_pkg::S_D_DIV: begin
        md_req.start  = !launched;
        md_req.op     = cpvp_pkg::OP_DIV;
        launched_next = 1'b1;
        if (md_rsp.done) begin
          launched_next = 1'b0;
          state_next    = cpvp_pkg::S_FIN;
        end
      end
      cpvp_pkg::S_FIN: begin
        // The item retires only when the output register is free or being emptied.
        fin_go = !out_valid || result.ready;
        if (fin_go) begin
          state_next = cpvp_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cpvp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cpvp_pkg::S_IDLE;
      launched  <= 1'b0;
      out_valid <= 1'b0;
      prev_enc  <= '0;
      integral  <= '0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
      if (state == cpvp_pkg::S_ERR) begin
        prev_enc <= enc_q;
      end
      if (fin_go) begin
        out_valid <= 1'b1;
        if (!d_clamped) begin
          integral <= integ_sat;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      enc_q  <= tick.encoder_count;
      ptgt_q <= tick.position_target;
      vtgt_q <= tick.velocity_target;
    end
    case (state)
      cpvp_pkg::S_ERR: begin
        pos_err <= {ptgt_q[31], ptgt_q} - {enc_q[31], enc_q};
        vel     <= vel_sat;
      end
      cpvp_pkg::S_CMD: begin
        cmd    <= cmd_clamped;
        on_tgt <= (pos_err <= win33) && (pos_err >= -win33);
      end
      cpvp_pkg::S_VERR: begin
        vel_err <= {{18{cmd[15]}}, cmd} - {{2{vel[31]}}, vel};
      end
      cpvp_pkg::S_SUM: begin
        work <= work + {{(cpvp_pkg::MAG_W-34){vel_err[33]}}, vel_err};
      end
      cpvp_pkg::S_FIN: begin
        if (fin_go) begin
          out_drive <= drive_val;
          out_on    <= on_tgt;
          out_vel   <= vel;
          out_cmd   <= cmd;
        end
      end
      default: ;
    endcase
    if (md_rsp.done) begin
      work <= md_rsp.result;
    end
  end

  assign result.valid              = out_valid;
  assign result.drive              = out_drive;
  assign result.position_on_target = out_on;
  assign result.measured_velocity  = out_vel;
  assign result.velocity_command   = out_cmd;

`ifndef SYNTH
  a_done_launched: assert property (@(posedge clk) disable iff (rst)
    md_rsp.done |-> launched)
    else $error("serial unit finished without a pending request");

  a_cmd_in_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_cmd <= lim16) && (out_cmd >= -lim16))
    else $error("velocity command outside the configured limit");

  a_integral_hold: assert property (@(posedge clk) disable iff (rst)
    (fin_go && d_clamped) |=> $stable(integral))
    else $error("integral changed while the drive was clamped");
`endif

endmodule

// ----- sim/cpvp_drive_checker.sv -----
// Checker for the cascaded controller: predicts each result from observed transfers and compares.
module cpvp_drive_checker (
  input  logic                          clk,
  input  logic                          rst,
  cpvp_tick_if                          tick,
  cpvp_result_if                        result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [cpvp_pkg::ADDR_W-1:0]   paddr,
  input  logic [cpvp_pkg::DATA_W-1:0]   pwdata,
  output int unsigned                   mismatches,
  output int unsigned                   outstanding,
  output int unsigned                   results_seen
);

  localparam longint SAT_MAX    = 64'sh7FFF_FFFF;
  localparam longint SAT_MIN    = -64'sh8000_0000;
  localparam longint DRIVE_SPAN = 127;

  typedef struct packed {
    logic [7:0]         drive;
    logic               on_target;
    logic signed [31:0] velocity;
    logic signed [15:0] command;
  } tick_outcome_t;

  tick_outcome_t      outcome_q[$];
  cpvp_pkg::cfg_t     settings;
  logic signed [31:0] last_count;
  logic signed [31:0] vel_integral;

  // One control tick: outer P loop, command clamp, encoder difference, inner PI loop.
  function automatic tick_outcome_t control_law(input logic signed [31:0] enc,
                                                input logic signed [31:0] ptgt,
                                                input logic signed [15:0] vtgt);
    longint e, p, v, divisor, lim, err, cmd, vel, verr, iterm, d;
    longint kpos, kp, ki, integ, prev, win, mag, center;
    tick_outcome_t o;
    e = enc;
    p = ptgt;
    v = vtgt;
    prev = last_count;
    integ = vel_integral;
    divisor = settings.gain_divisor;
    if (divisor == 0) divisor = 1;
    lim = settings.velocity_limit;
    kpos = settings.position_gain;
    kp = settings.velocity_p_gain;
    ki = settings.velocity_i_gain;
    win = settings.on_target_window;
    center = cpvp_pkg::DRIVE_CENTER;

    err = p - e;
    if (settings.cascade_mode) cmd = (err * kpos) / divisor;
    else cmd = v;
    if (cmd > lim) cmd = lim;
    else if (cmd < -lim) cmd = -lim;

    vel = e - prev;
    if (vel > SAT_MAX) vel = SAT_MAX;
    else if (vel < SAT_MIN) vel = SAT_MIN;

    verr = cmd - vel;
    iterm = (ki * integ) / divisor;
    d = ((verr + iterm) * kp) / divisor;
    last_count = enc;

    // The integral only moves while the drive stays inside its range.
    if (d > DRIVE_SPAN) d = DRIVE_SPAN;
    else if (d < -DRIVE_SPAN) d = -DRIVE_SPAN;
    else begin
      integ = integ + verr;
      if (integ > SAT_MAX) integ = SAT_MAX;
      else if (integ < SAT_MIN) integ = SAT_MIN;
      vel_integral = integ[31:0];
    end

    mag = (err < 0) ? -err : err;
    o.on_target = (mag <= win);
    o.drive = settings.motor_reverse ? 8'(center - d) : 8'(center + d);
    o.velocity = vel[31:0];
    o.command = cmd[15:0];
    return o;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch on result %0d, %s: expected %0d, got %0d",
                 results_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    tick_outcome_t want;
    if (rst) begin
      outcome_q.delete();
      settings.cascade_mode = 1'b0;
      settings.position_gain = '0;
      settings.gain_divisor = cpvp_pkg::DIVISOR_RESET;
      settings.velocity_p_gain = '0;
      settings.velocity_i_gain = '0;
      settings.velocity_limit = cpvp_pkg::LIMIT_RESET;
      settings.motor_reverse = 1'b0;
      settings.on_target_window = cpvp_pkg::WINDOW_RESET;
      last_count = '0;
      vel_integral = '0;
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cpvp_pkg::reg_idx_t'(paddr[cpvp_pkg::ADDR_W-1:2]))
          cpvp_pkg::REG_CASCADE_MODE:     settings.cascade_mode = pwdata[0];
          cpvp_pkg::REG_POSITION_GAIN:    settings.position_gain = pwdata[14:0];
          cpvp_pkg::REG_GAIN_DIVISOR:     settings.gain_divisor = pwdata[14:0];
          cpvp_pkg::REG_VELOCITY_P_GAIN:  settings.velocity_p_gain = pwdata[14:0];
          cpvp_pkg::REG_VELOCITY_I_GAIN:  settings.velocity_i_gain = pwdata[14:0];
          cpvp_pkg::REG_VELOCITY_LIMIT:   settings.velocity_limit = pwdata[14:0];
          cpvp_pkg::REG_MOTOR_REVERSE:    settings.motor_reverse = pwdata[0];
          cpvp_pkg::REG_ON_TARGET_WINDOW: settings.on_target_window = pwdata[15:0];
          default: ;
        endcase
      end
      if (tick.valid && tick.ready)
        outcome_q.push_back(control_law(tick.encoder_count, tick.position_target,
                                        tick.velocity_target));
      if (result.valid && result.ready) begin
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected result transfer: drive %0d, velocity %0d, command %0d",
                     result.drive, result.measured_velocity, result.velocity_command);
        end else begin
          want = outcome_q.pop_front();
          check_field("drive", want.drive, result.drive);
          check_field("on_target", want.on_target, result.position_on_target);
          check_field("measured_velocity", want.velocity, result.measured_velocity);
          check_field("velocity_command", want.command, result.velocity_command);
        end
        results_seen++;
      end
    end
    outstanding <= outcome_q.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top: clock, reset, tick and register stimulus, result stalls and the verdict.
module tb_top;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [cpvp_pkg::ADDR_W-1:0]   paddr;
  logic [cpvp_pkg::DATA_W-1:0]   pwdata;
  logic [cpvp_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned ticks_sent = 0;
  int unsigned settings_used = 1;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;

  cpvp_tick_if   tick_ch ();
  cpvp_result_if result_ch ();

  cascaded_position_velocity_pid dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cpvp_drive_checker drive_check (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick_ch),
    .result       (result_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #6000000;
    $display("Timeout with %0d results still outstanding", outstanding);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stall before each transfer, or none in quiet stretches.
  initial begin
    int unsigned stall;
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
    end
  end

  function automatic logic [cpvp_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 15'h7FFF;
      2: return 15'd1;
      3: return 15'($urandom_range(1, 16));
      4: return 15'($urandom_range(1, 1000));
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  task automatic send_tick(input logic signed [31:0] enc, input logic signed [31:0] ptgt,
                           input logic signed [15:0] vtgt);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.encoder_count <= enc;
    tick_ch.position_target <= ptgt;
    tick_ch.velocity_target <= vtgt;
    do @(posedge clk); while (!(tick_ch.valid && tick_ch.ready));
    ticks_sent++;
  endtask

  // Stop sending and let every expected result come back.
  task automatic wait_idle();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input cpvp_pkg::reg_idx_t idx,
                           input logic [cpvp_pkg::DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_settings(input cpvp_pkg::cfg_t c);
    wait_idle();
    write_reg(cpvp_pkg::REG_CASCADE_MODE, cpvp_pkg::DATA_W'(c.cascade_mode));
    write_reg(cpvp_pkg::REG_POSITION_GAIN, cpvp_pkg::DATA_W'(c.position_gain));
    write_reg(cpvp_pkg::REG_GAIN_DIVISOR, cpvp_pkg::DATA_W'(c.gain_divisor));
    write_reg(cpvp_pkg::REG_VELOCITY_P_GAIN, cpvp_pkg::DATA_W'(c.velocity_p_gain));
    write_reg(cpvp_pkg::REG_VELOCITY_I_GAIN, cpvp_pkg::DATA_W'(c.velocity_i_gain));
    write_reg(cpvp_pkg::REG_VELOCITY_LIMIT, cpvp_pkg::DATA_W'(c.velocity_limit));
    write_reg(cpvp_pkg::REG_MOTOR_REVERSE, cpvp_pkg::DATA_W'(c.motor_reverse));
    write_reg(cpvp_pkg::REG_ON_TARGET_WINDOW, cpvp_pkg::DATA_W'(c.on_target_window));
    settings_used++;
  endtask

  initial begin
    cpvp_pkg::cfg_t     c;
    int                 track;
    int                 goal;
    int unsigned        kind;
    logic signed [31:0] enc;
    logic signed [31:0] ptgt;
    logic signed [15:0] vtgt;

    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.encoder_count <= '0;
    tick_ch.position_target <= '0;
    tick_ch.velocity_target <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: velocity mode, zero gains, window of ten counts.
    send_tick(32'sd0, 32'sd0, 16'sd0);
    send_tick(32'sd10, 32'sd0, 16'sh7FFF);
    send_tick(32'sd0, 32'sd11, -16'sh8000);
    send_tick(32'sh7FFF_FFFF, -32'sh8000_0000, 16'sd1);
    // Encoder jumps across the full range saturate the measured velocity both ways.
    send_tick(-32'sh8000_0000, 32'sh7FFF_FFFF, -16'sd1);
    send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'sd0);
    send_tick(-32'sd1, -32'sd1, -16'sd1);

    // Cascade with full position gain, a zero divisor and a reversed motor.
    c = '{cascade_mode: 1'b1, position_gain: 15'h7FFF, gain_divisor: 15'd0,
          velocity_p_gain: 15'd1, velocity_i_gain: 15'd1, velocity_limit: 15'd100,
          motor_reverse: 1'b1, on_target_window: 16'hFFFF};
    load_settings(c);
    send_tick(32'sd0, 32'sd65535, 16'sd0);
    send_tick(32'sd0, -32'sd65536, 16'sd0);
    send_tick(32'sd0, 32'sd0, 16'sd0);
    send_tick(32'sd5, 32'sd5, 16'sd0);
    send_tick(32'sh7FFF_FFFF, -32'sh8000_0000, 16'sd0);
    send_tick(-32'sh8000_0000, 32'sh7FFF_FFFF, 16'sd0);

    // Zero command limit and zero window; the integral builds up over small moves.
    c = '{cascade_mode: 1'b1, position_gain: 15'd3, gain_divisor: 15'h7FFF,
          velocity_p_gain: 15'h7FFF, velocity_i_gain: 15'h7FFF, velocity_limit: 15'd0,
          motor_reverse: 1'b0, on_target_window: 16'd0};
    load_settings(c);
    send_tick(32'sd0, 32'sd0, 16'sd0);
    send_tick(32'sd3, 32'sd4, 16'sd0);
    send_tick(32'sd3, 32'sd3, 16'sd0);
    send_tick(32'sd6, 32'sd5, 16'sd0);
    send_tick(-32'sd4, -32'sd4, 16'sd0);

    // Velocity mode at full gain drives the output into both clamps.
    c = '{cascade_mode: 1'b0, position_gain: 15'd0, gain_divisor: 15'd1,
          velocity_p_gain: 15'h7FFF, velocity_i_gain: 15'd0, velocity_limit: 15'h7FFF,
          motor_reverse: 1'b0, on_target_window: 16'd10};
    load_settings(c);
    send_tick(-32'sd4, 32'sd0, 16'sh7FFF);
    send_tick(-32'sd4, 32'sd0, -16'sh8000);
    send_tick(-32'sd4, 32'sd0, 16'sd0);

    track = 0;
    for (int phase = 0; phase < 16; phase++) begin
      c.cascade_mode = $urandom_range(0, 1);
      c.position_gain = pick_gain();
      c.gain_divisor = pick_gain();
      c.velocity_p_gain = $urandom_range(0, 1) ? pick_gain()
                                                : 15'($urandom_range(0, c.gain_divisor));
      c.velocity_i_gain = pick_gain();
      c.velocity_limit = pick_gain();
      c.motor_reverse = $urandom_range(0, 1);
      case ($urandom_range(0, 3))
        0: c.on_target_window = 16'd0;
        1: c.on_target_window = 16'hFFFF;
        2: c.on_target_window = 16'($urandom_range(0, 40));
        default: c.on_target_window = 16'($urandom);
      endcase
      load_settings(c);
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      goal = track + int'($urandom_range(0, 4000)) - 2000;

      repeat (102) begin
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
          // Encoder closes in on the goal with jitter; the goal moves now and then.
          track = track + (goal - track) / 8 + int'($urandom_range(0, 20)) - 10;
          enc = track;
          ptgt = goal;
          vtgt = 16'(int'($urandom_range(0, 400)) - 200);
          if ($urandom_range(0, 15) == 0)
            goal = track + int'($urandom_range(0, 4000)) - 2000;
        end else if (kind < 90) begin
          track = $urandom;
          goal = track + int'($urandom_range(0, 200)) - 100;
          enc = track;
          ptgt = goal;
          vtgt = 16'($urandom);
        end else begin
          enc = $urandom;
          ptgt = $urandom;
          vtgt = 16'($urandom);
        end
        send_tick(enc, ptgt, vtgt);
      end
    end

    tx_quiet = 1'b0;
    wait_idle();
    repeat (300) @(posedge clk);

    $display("Ran %0d control ticks over %0d register settings in both loop modes.",
             ticks_sent, settings_used);
    $display("Compared %0d results, %0d field mismatches.", results_seen, mismatches);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
design/cpvp_pkg.sv
design/cpvp_if.sv
design/cpvp_regs.sv
design/cpvp_muldiv.sv
design/cascaded_position_velocity_pid.sv
sim/cpvp_drive_checker.sv
sim/tb_top.sv
